// ----- hw/rtl/pib_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pib_pkg
// Shared types and constants for the pinhole project / back-project unit.
// ----------------------------------------------------------------------------
package pib_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int NUM_W      = 64;
  localparam int DIV_STAGES = NUM_W;
  localparam int CLAMP_W    = 41;
  localparam int SQ_W       = CLAMP_W + 1;
  localparam int SUM_W      = SQ_W + 1;
  localparam int ADDR_W     = 4;

  localparam logic [CLAMP_W-1:0] QCLAMP = CLAMP_W'(1) << (CLAMP_W - 1);
  localparam logic [DATA_W-1:0]  FOCAL_ONE = DATA_W'(1) << FRAC_BITS;

  // operation codes
  localparam logic OP_PROJECT = 1'b0;
  localparam logic OP_BACK    = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDIV = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_FOCAL_X  = 2'd0;
  localparam logic [1:0] REG_FOCAL_Y  = 2'd1;
  localparam logic [1:0] REG_CENTER_X = 2'd2;
  localparam logic [1:0] REG_CENTER_Y = 2'd3;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] coord_a;
    logic signed [31:0] coord_b;
    logic signed [31:0] coord_c;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_a;
    logic signed [31:0] out_b;
    logic signed [31:0] out_c;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic [DATA_W-1:0] focal_x;
    logic [DATA_W-1:0] focal_y;
    logic [DATA_W-1:0] center_x;
    logic [DATA_W-1:0] center_y;
  } cfg_t;

  // per-transaction control that rides along the divider chain
  typedef struct packed {
    logic              op;
    logic              zero;
    logic              neg_a;
    logic              neg_b;
    logic [DATA_W-1:0] coord_c;
  } side_t;

  // one divider lane: numerator bits shift out as quotient bits shift in
  typedef struct packed {
    logic [NUM_W-1:0]  nq;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] den;
  } div_t;

  typedef struct packed {
    logic  valid;
    side_t side;
    div_t  a;
    div_t  b;
  } stage_t;

endpackage

// ----- hw/rtl/pib_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pib_front
// Operand preparation and the two wide products that feed the divider chain.
// ----------------------------------------------------------------------------
module pib_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  pib_pkg::in_t     in_data,
  input  pib_pkg::cfg_t    cfg,
  output pib_pkg::stage_t  stage_out
);

  logic                        op;
  logic [33:0]                 da;
  logic [33:0]                 db;
  logic [32:0]                 mag_a;
  logic [32:0]                 mag_b;
  logic [31:0]                 mag_c;
  logic                        sa;
  logic                        sb;
  logic                        sc;

  logic                        v1_r;
  pib_pkg::side_t              side1_r;
  logic [32:0]                 ma_r;
  logic [32:0]                 mb_r;
  logic [31:0]                 fa_r;
  logic [31:0]                 fb_r;
  logic [31:0]                 dena_r;
  logic [31:0]                 denb_r;

  logic [64:0]                 prod_a;
  logic [64:0]                 prod_b;
  pib_pkg::stage_t             st_r;

  // signs, magnitudes and centered pixel offsets
  always_comb begin
    op = in_data.operation;
    da = {{2{in_data.coord_a[31]}}, in_data.coord_a} - {2'b00, cfg.center_x};
    db = {{2{in_data.coord_b[31]}}, in_data.coord_b} - {2'b00, cfg.center_y};
    sc = in_data.coord_c[31];
    mag_c = sc ? 32'(-in_data.coord_c) : in_data.coord_c;
    if (op == pib_pkg::OP_BACK) begin
      sa = da[33];
      sb = db[33];
      mag_a = sa ? 33'(-da) : da[32:0];
      mag_b = sb ? 33'(-db) : db[32:0];
    end else begin
      sa = in_data.coord_a[31];
      sb = in_data.coord_b[31];
      mag_a = {1'b0, sa ? 32'(-in_data.coord_a) : in_data.coord_a};
      mag_b = {1'b0, sb ? 32'(-in_data.coord_b) : in_data.coord_b};
    end
  end

  // operand register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    side1_r.op      <= op;
    side1_r.neg_a   <= sa ^ sc;
    side1_r.neg_b   <= sb ^ sc;
    side1_r.coord_c <= in_data.coord_c;
    ma_r            <= mag_a;
    mb_r            <= mag_b;
    if (op == pib_pkg::OP_BACK) begin
      side1_r.zero <= (cfg.focal_x == '0) || (cfg.focal_y == '0);
      fa_r         <= mag_c;
      fb_r         <= mag_c;
      dena_r       <= cfg.focal_x;
      denb_r       <= cfg.focal_y;
    end else begin
      side1_r.zero <= (in_data.coord_c == '0);
      fa_r         <= cfg.focal_x;
      fb_r         <= cfg.focal_y;
      dena_r       <= mag_c;
      denb_r       <= mag_c;
    end
  end

  // numerators, exact products
  assign prod_a = ma_r * fa_r;
  assign prod_b = mb_r * fb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else begin
      st_r.valid <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    st_r.side  <= side1_r;
    st_r.a.nq  <= prod_a[63:0];
    st_r.a.rem <= '0;
    st_r.a.den <= dena_r;
    st_r.b.nq  <= prod_b[63:0];
    st_r.b.rem <= '0;
    st_r.b.den <= denb_r;
  end

  assign stage_out = st_r;

endmodule

// ----- hw/rtl/pib_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pib_div_cell
// One restoring division step for both lanes; hands its result to the next cell.
// ----------------------------------------------------------------------------
module pib_div_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  pib_pkg::stage_t  stage_in,
  output pib_pkg::stage_t  stage_out
);

  logic [32:0]     part_a;
  logic [32:0]     part_b;
  logic            ge_a;
  logic            ge_b;
  logic [32:0]     diff_a;
  logic [32:0]     diff_b;
  pib_pkg::stage_t st_r;

  // shift in the next numerator bit and try the subtract
  always_comb begin
    part_a = {stage_in.a.rem, stage_in.a.nq[pib_pkg::NUM_W-1]};
    part_b = {stage_in.b.rem, stage_in.b.nq[pib_pkg::NUM_W-1]};
    diff_a = part_a - {1'b0, stage_in.a.den};
    diff_b = part_b - {1'b0, stage_in.b.den};
    ge_a   = part_a >= {1'b0, stage_in.a.den};
    ge_b   = part_b >= {1'b0, stage_in.b.den};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else begin
      st_r.valid <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    st_r.side  <= stage_in.side;
    st_r.a.den <= stage_in.a.den;
    st_r.b.den <= stage_in.b.den;
    st_r.a.nq  <= {stage_in.a.nq[pib_pkg::NUM_W-2:0], ge_a};
    st_r.b.nq  <= {stage_in.b.nq[pib_pkg::NUM_W-2:0], ge_b};
    st_r.a.rem <= ge_a ? diff_a[31:0] : part_a[31:0];
    st_r.b.rem <= ge_b ? diff_b[31:0] : part_b[31:0];
  end

  assign stage_out = st_r;

endmodule

// ----- hw/rtl/pib_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pib_back
// Quotient clamp, sign, center offset and saturation into the result register.
// ----------------------------------------------------------------------------
module pib_back (
  input  logic             clk,
  input  logic             rst_n,
  input  pib_pkg::stage_t  stage_in,
  input  pib_pkg::cfg_t    cfg,
  output logic             out_valid,
  output pib_pkg::out_t    out_data
);

  logic [pib_pkg::CLAMP_W-1:0]      qa_c;
  logic [pib_pkg::CLAMP_W-1:0]      qb_c;
  logic                             v_r;
  pib_pkg::side_t                   side_r;
  logic signed [pib_pkg::SQ_W-1:0]  sqa_r;
  logic signed [pib_pkg::SQ_W-1:0]  sqb_r;

  logic signed [pib_pkg::SUM_W-1:0] sum_a;
  logic signed [pib_pkg::SUM_W-1:0] sum_b;
  logic [31:0]                      sat_a;
  logic [31:0]                      sat_b;
  logic                             ov_a;
  logic                             ov_b;
  logic                             ov_any;
  logic                             vo_r;
  pib_pkg::out_t                    res_r;

  // clamp quotient magnitudes far beyond the output range
  always_comb begin
    qa_c = (stage_in.a.nq > 64'(pib_pkg::QCLAMP)) ? pib_pkg::QCLAMP
                                                  : stage_in.a.nq[pib_pkg::CLAMP_W-1:0];
    qb_c = (stage_in.b.nq > 64'(pib_pkg::QCLAMP)) ? pib_pkg::QCLAMP
                                                  : stage_in.b.nq[pib_pkg::CLAMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= stage_in.valid;
    end
  end

  // apply sign
  always_ff @(posedge clk) begin
    side_r <= stage_in.side;
    sqa_r  <= stage_in.side.neg_a ? -$signed({1'b0, qa_c}) : $signed({1'b0, qa_c});
    sqb_r  <= stage_in.side.neg_b ? -$signed({1'b0, qb_c}) : $signed({1'b0, qb_c});
  end

  // add center on project, then saturate to 32 bits
  always_comb begin
    sum_a = pib_pkg::SUM_W'(sqa_r);
    sum_b = pib_pkg::SUM_W'(sqb_r);
    if (side_r.op == pib_pkg::OP_PROJECT) begin
      sum_a = sum_a + $signed({{(pib_pkg::SUM_W-32){1'b0}}, cfg.center_x});
      sum_b = sum_b + $signed({{(pib_pkg::SUM_W-32){1'b0}}, cfg.center_y});
    end
    ov_a = 1'b1;
    ov_b = 1'b1;
    if (sum_a > $signed(pib_pkg::SUM_W'(32'sh7fffffff))) begin
      sat_a = 32'h7fffffff;
    end else if (sum_a < -$signed(pib_pkg::SUM_W'(64'h80000000))) begin
      sat_a = 32'h80000000;
    end else begin
      sat_a = sum_a[31:0];
      ov_a  = 1'b0;
    end
    if (sum_b > $signed(pib_pkg::SUM_W'(32'sh7fffffff))) begin
      sat_b = 32'h7fffffff;
    end else if (sum_b < -$signed(pib_pkg::SUM_W'(64'h80000000))) begin
      sat_b = 32'h80000000;
    end else begin
      sat_b = sum_b[31:0];
      ov_b  = 1'b0;
    end
    ov_any = ov_a | ov_b;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (side_r.zero) begin
      res_r.out_a  <= '0;
      res_r.out_b  <= '0;
      res_r.out_c  <= '0;
      res_r.status <= pib_pkg::ST_ZDIV;
    end else begin
      res_r.out_a  <= sat_a;
      res_r.out_b  <= sat_b;
      res_r.out_c  <= (side_r.op == pib_pkg::OP_BACK) ? side_r.coord_c : '0;
      res_r.status <= ov_any ? pib_pkg::ST_SAT : pib_pkg::ST_OK;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = res_r;

endmodule

// ----- hw/rtl/pinhole_project_backproject.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_project_backproject
// Pinhole camera intrinsics unit: project points to pixels, back-project
// pixels with depth to points, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// The unit takes one transaction per clock: busy is always low and start may
// be held high every cycle. Each transaction yields one result on out_data
// with out_valid high for one cycle, in input order, after passing through
// one operand register, one multiplier stage, a chain of 64
// restoring-division cells (one quotient bit each) and two output stages.
// Results cannot be held off. Intrinsics are written over the APB port at
// addresses 0x0 focal_x, 0x4 focal_y, 0x8 center_x, 0xC center_y; write them
// only while no transaction is in flight.
// ----------------------------------------------------------------------------
module pinhole_project_backproject (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  pib_pkg::in_t                  in_data,
  output logic                          out_valid,
  output pib_pkg::out_t                 out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pib_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  pib_pkg::cfg_t   cfg_r;
  logic            wr_en;
  pib_pkg::stage_t chain [0:pib_pkg::DIV_STAGES];

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.focal_x  <= pib_pkg::FOCAL_ONE;
      cfg_r.focal_y  <= pib_pkg::FOCAL_ONE;
      cfg_r.center_x <= '0;
      cfg_r.center_y <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        pib_pkg::REG_FOCAL_X:  cfg_r.focal_x  <= pwdata;
        pib_pkg::REG_FOCAL_Y:  cfg_r.focal_y  <= pwdata;
        pib_pkg::REG_CENTER_X: cfg_r.center_x <= pwdata;
        pib_pkg::REG_CENTER_Y: cfg_r.center_y <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      pib_pkg::REG_FOCAL_X:  prdata = cfg_r.focal_x;
      pib_pkg::REG_FOCAL_Y:  prdata = cfg_r.focal_y;
      pib_pkg::REG_CENTER_X: prdata = cfg_r.center_x;
      pib_pkg::REG_CENTER_Y: prdata = cfg_r.center_y;
      default:               prdata = '0;
    endcase
  end

  // operands and products
  pib_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (start & ~busy),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .stage_out (chain[0])
  );

  // divider chain, one quotient bit per cell
  for (genvar i = 0; i < pib_pkg::DIV_STAGES; i++) begin : g_cell
    pib_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_in  (chain[i]),
      .stage_out (chain[i+1])
    );
  end

  // offset, saturation and result register
  pib_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage_in  (chain[pib_pkg::DIV_STAGES]),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pinhole project / back-project unit: a directed
// table followed by random transactions over several intrinsic settings, each
// result compared field by field with a fixed-point camera predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int LATENCY   = 68;
  localparam int WD_LIMIT  = 4000;
  localparam int N_RANDOM  = 700;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  pib_pkg::in_t  in_data = '0;
  logic        out_valid;
  pib_pkg::out_t out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [pib_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pinhole_project_backproject DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // predictor copy of the intrinsics
  pib_pkg::cfg_t cam;
  pib_pkg::out_t pixel_q[$];
  int    err_cnt = 0;
  int    sent = 0;
  int    got = 0;
  int    idle_cycles = 0;
  int    send_idle_pct = 0;

  task automatic report_mismatch(input string what, input logic [31:0] g,
                                 input logic [31:0] e);
    $display("MISMATCH %s got %h exp %h at %0t", what, g, e, $time);
    err_cnt++;
  endtask

  function automatic logic [63:0] magnitude(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [63:0] div_signed(input logic [63:0] num,
                                                    input logic [63:0] den,
                                                    input bit neg);
    logic [63:0] q;
    q = num / den;
    if (q > 64'h100_0000_0000) q = 64'h100_0000_0000;
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [63:0] v,
                                          inout bit ov);
    if (v > 64'sd2147483647) begin
      ov = 1;
      return 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      ov = 1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic pib_pkg::out_t camera_model(input pib_pkg::in_t t);
    pib_pkg::out_t r;
    logic signed [63:0] a, b, c, da, db, qa, qb;
    bit ov;
    r = '0;
    ov = 0;
    a = t.coord_a;
    b = t.coord_b;
    c = t.coord_c;
    if (t.operation == pib_pkg::OP_PROJECT) begin
      if (c == 0) begin
        r.status = pib_pkg::ST_ZDIV;
        return r;
      end
      qa = div_signed({32'd0, cam.focal_x} * magnitude(a), magnitude(c), (a < 0) != (c < 0));
      qb = div_signed({32'd0, cam.focal_y} * magnitude(b), magnitude(c), (b < 0) != (c < 0));
      r.out_a = clamp32(qa + $signed({32'd0, cam.center_x}), ov);
      r.out_b = clamp32(qb + $signed({32'd0, cam.center_y}), ov);
    end else begin
      if (cam.focal_x == 0 || cam.focal_y == 0) begin
        r.status = pib_pkg::ST_ZDIV;
        return r;
      end
      da = a - $signed({32'd0, cam.center_x});
      db = b - $signed({32'd0, cam.center_y});
      qa = div_signed(magnitude(da) * magnitude(c), {32'd0, cam.focal_x}, (da < 0) != (c < 0));
      qb = div_signed(magnitude(db) * magnitude(c), {32'd0, cam.focal_y}, (db < 0) != (c < 0));
      r.out_a = clamp32(qa, ov);
      r.out_b = clamp32(qb, ov);
      r.out_c = t.coord_c;
    end
    r.status = ov ? pib_pkg::ST_SAT : pib_pkg::ST_OK;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got <= got + 1;
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected result", out_data.out_a, 32'd0);
      end else begin
        pib_pkg::out_t e;
        e = pixel_q.pop_front();
        if (out_data.out_a !== e.out_a) report_mismatch("out_a", out_data.out_a, e.out_a);
        if (out_data.out_b !== e.out_b) report_mismatch("out_b", out_data.out_b, e.out_b);
        if (out_data.out_c !== e.out_c) report_mismatch("out_c", out_data.out_c, e.out_c);
        if (out_data.status !== e.status)
          report_mismatch("status", 32'(out_data.status), 32'(e.status));
      end
    end
  end

  // watchdog on cycles with no accepted transaction, result or register access
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= pib_pkg::ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      pib_pkg::REG_FOCAL_X:  cam.focal_x = val;
      pib_pkg::REG_FOCAL_Y:  cam.focal_y = val;
      pib_pkg::REG_CENTER_X: cam.center_x = val;
      default:               cam.center_y = val;
    endcase
  endtask

  // wait until every queued result has come, then the pipeline depth
  task automatic drain();
    start <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_camera(input logic [31:0] fx, input logic [31:0] fy,
                            input logic [31:0] cx, input logic [31:0] cy);
    drain();
    write_reg(pib_pkg::REG_FOCAL_X, fx);
    write_reg(pib_pkg::REG_FOCAL_Y, fy);
    write_reg(pib_pkg::REG_CENTER_X, cx);
    write_reg(pib_pkg::REG_CENTER_Y, cy);
  endtask

  // drive one transaction, held until accepted; the caller lowers start
  task automatic send_point(input pib_pkg::in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (busy);
    pixel_q.push_back(camera_model(t));
    sent++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return $urandom_range(3) - 1;
      default: return {{14{$urandom_range(1) == 1}}, 18'($urandom)};
    endcase
  endfunction

  typedef struct {
    pib_pkg::in_t  t;
    bit            known;
    pib_pkg::out_t e;
  } row_t;

  row_t dir_tab[$];

  task automatic add_row(input logic op, input logic [31:0] a, input logic [31:0] b,
                         input logic [31:0] c, input bit known, input pib_pkg::out_t e);
    row_t r;
    r.t = '{op, a, b, c};
    r.known = known;
    r.e = e;
    dir_tab.push_back(r);
  endtask

  initial begin
    pib_pkg::in_t t;
    pib_pkg::out_t ex;
    cam = '{pib_pkg::FOCAL_ONE, pib_pkg::FOCAL_ONE, 32'd0, 32'd0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed table at reset intrinsics
    ex = '0; ex.status = pib_pkg::ST_ZDIV;
    add_row(pib_pkg::OP_PROJECT, 32'h0001_0000, 32'h0001_0000, 32'd0, 1, ex);
    ex = '{32'h0002_0000, 32'h0003_0000, 32'd0, pib_pkg::ST_OK};
    add_row(pib_pkg::OP_PROJECT, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 1, ex);
    ex = '{32'h0002_0000, 32'h0003_0000, 32'h0001_0000, pib_pkg::ST_OK};
    add_row(pib_pkg::OP_BACK, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 1, ex);
    ex = '{32'h7fff_ffff, 32'h8000_0000, 32'd0, pib_pkg::ST_SAT};
    add_row(pib_pkg::OP_PROJECT, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 1, ex);
    ex = '0;
    add_row(pib_pkg::OP_PROJECT, 32'h0, 32'h0, 32'h8000_0000, 1, ex);
    add_row(pib_pkg::OP_BACK, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, ex);
    add_row(pib_pkg::OP_BACK, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, ex);
    add_row(pib_pkg::OP_PROJECT, 32'hffff_ffff, 32'h1234_5678, 32'hffff_0000, 0, ex);
    add_row(pib_pkg::OP_BACK, 32'hffff_ffff, 32'h0000_0001, 32'h0, 0, ex);
    add_row(pib_pkg::OP_PROJECT, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0, ex);
    foreach (dir_tab[i]) begin
      send_point(dir_tab[i].t);
      if (dir_tab[i].known) pixel_q[pixel_q.size()-1] = dir_tab[i].e;
    end

    // zero focal lengths: back-project reports zero divisor
    set_camera(32'd0, pib_pkg::FOCAL_ONE, 32'd0, 32'd0);
    ex = '0; ex.status = pib_pkg::ST_ZDIV;
    t = '{pib_pkg::OP_BACK, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
    send_point(t);
    pixel_q[pixel_q.size()-1] = ex;
    set_camera(pib_pkg::FOCAL_ONE, 32'd0, 32'd0, 32'd0);
    send_point(t);
    pixel_q[pixel_q.size()-1] = ex;
    send_point('{pib_pkg::OP_PROJECT, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0003});
    // extreme intrinsics
    set_camera(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_point('{pib_pkg::OP_PROJECT, 32'h7fff_ffff, 32'h8000_0000, 32'd1});
    send_point('{pib_pkg::OP_BACK, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
    send_point('{pib_pkg::OP_BACK, 32'h0, 32'hffff_ffff, 32'h7fff_ffff});
    send_point('{pib_pkg::OP_PROJECT, 32'h0, 32'h0, 32'hffff_ffff});

    // random phases over several camera settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_camera(32'h0200_0000, 32'h01e0_0000, 32'h0140_0000, 32'h00f0_0000);
        1: set_camera($urandom, $urandom, $urandom, $urandom);
        2: set_camera(32'd1, 32'd1, 32'd0, 32'd0);
        3: set_camera(32'hffff_ffff, 32'd1, 32'h8000_0000, 32'h7fff_ffff);
        4: set_camera(32'h0001_0000, 32'h0001_0000, 32'hffff_ffff, 32'd0);
        5: set_camera($urandom_range(32'h0400_0000), $urandom_range(32'h0400_0000),
                      $urandom_range(32'h0200_0000), $urandom_range(32'h0200_0000));
        default: set_camera($urandom, 32'd0, $urandom, $urandom);
      endcase
      send_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 62 : 0;
      for (int i = 0; i < N_RANDOM / 7; i++) begin
        t.operation = 1'($urandom_range(1));
        t.coord_a = rand_coord();
        t.coord_b = rand_coord();
        t.coord_c = rand_coord();
        send_point(t);
        // hold the sender until the pipe is empty once per phase
        if (i == 40) begin
          start <= 1'b0;
          while (pixel_q.size() != 0) @(posedge clk);
        end
      end
    end

    drain();
    $display("sent %0d transactions, checked %0d results over 11 camera settings",
             sent, got);
    $display("covered project, back-project, zero divisor and saturation cases");
    if (err_cnt == 0 && pixel_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
